// ===== design/sdld_pkg.sv =====
// ----------------------------------------------------------------------------
// sdld_pkg
// Shared types and constants for the signed decimal long divider.
// ----------------------------------------------------------------------------
package sdld_pkg;

  localparam int OPERAND_WIDTH       = 32;
  localparam int MAX_FRACTION_DIGITS = 15;
  localparam int RADIX               = 10;
  localparam int DIGIT_WIDTH         = 4;
  localparam int PLACE_WIDTH         = 4;
  localparam int STEP_CNT_WIDTH      = $clog2(OPERAND_WIDTH);
  localparam int TEN_R_WIDTH         = OPERAND_WIDTH + DIGIT_WIDTH - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INT_DIV,
    ST_EMIT,
    ST_FRAC_LOAD,
    ST_FRAC_DIV
  } state_t;

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] rem;
    logic                     qbit;
  } step_res_t;

endpackage

// ===== design/sdld_step.sv =====
// ----------------------------------------------------------------------------
// sdld_step
// One restoring division step: shift in one bit, compare and subtract.
// ----------------------------------------------------------------------------
module sdld_step
  import sdld_pkg::*;
(
  input  logic [OPERAND_WIDTH-1:0] rem_in,
  input  logic                     bit_in,
  input  logic [OPERAND_WIDTH-1:0] divisor_mag,
  output step_res_t                res
);

  logic [OPERAND_WIDTH:0]   trial;
  logic [OPERAND_WIDTH+1:0] diff;

  assign trial = {rem_in, bit_in};
  assign diff  = {1'b0, trial} - {2'b00, divisor_mag};

  always_comb begin
    res.qbit = ~diff[OPERAND_WIDTH+1];
    if (res.qbit) begin
      res.rem = diff[OPERAND_WIDTH-1:0];
    end else begin
      res.rem = trial[OPERAND_WIDTH-1:0];
    end
  end

endmodule

// ===== design/signed_decimal_long_divider_core.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_long_divider_core
// Signed division producing the integer quotient and then decimal digits.
// ----------------------------------------------------------------------------
// One request is taken when the core is idle. Signs are stripped and their
// XOR reported on every result. The integer magnitude is formed bit by bit
// by a single restoring compare-subtract unit. Each fraction digit is made
// in steps: ten times the remainder is formed, four steps of the same unit
// follow, and the digit is then loaded into the output register. The core
// waits to load while the output register is still full and not being
// taken. The stream ends with last set after the requested count or once
// the remainder is zero; a zero divisor gives one result with
// divide_by_zero set. The output register lets the core go back to idle
// while the final result waits to be taken.
module signed_decimal_long_divider_core
  import sdld_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [OPERAND_WIDTH-1:0] dividend,
  input  logic signed [OPERAND_WIDTH-1:0] divisor,
  input  logic [DIGIT_WIDTH-1:0]          fraction_digits,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [OPERAND_WIDTH-1:0]        digit_value,
  output logic [PLACE_WIDTH-1:0]          place,
  output logic                            negative,
  output logic                            divide_by_zero,
  output logic                            last
);

  state_t state, state_next;

  logic [OPERAND_WIDTH-1:0]  rem;
  logic [OPERAND_WIDTH-1:0]  sh;
  logic [OPERAND_WIDTH-1:0]  quo;
  logic [OPERAND_WIDTH-1:0]  bmag;
  logic [STEP_CNT_WIDTH-1:0] cnt;
  logic [PLACE_WIDTH-1:0]    cur_place;
  logic [DIGIT_WIDTH-1:0]    digits;
  logic                      neg;
  logic                      dbz;

  logic [OPERAND_WIDTH-1:0]  a_in_mag;
  logic [OPERAND_WIDTH-1:0]  b_in_mag;
  logic [TEN_R_WIDTH-1:0]    ten_r;
  logic                      last_now;
  logic                      load_out;
  logic                      accept;
  step_res_t                 step;

  assign a_in_mag = dividend[OPERAND_WIDTH-1] ? OPERAND_WIDTH'(-dividend)
                                              : OPERAND_WIDTH'(dividend);
  assign b_in_mag = divisor[OPERAND_WIDTH-1] ? OPERAND_WIDTH'(-divisor)
                                             : OPERAND_WIDTH'(divisor);
  assign ten_r    = {rem, 3'b000} + {2'b00, rem, 1'b0};
  assign last_now = dbz || (rem == '0) || (cur_place == digits);
  assign accept   = in_valid && in_ready;

  sdld_step u_step (
    .rem_in      (rem),
    .bit_in      (sh[OPERAND_WIDTH-1]),
    .divisor_mag (bmag),
    .res         (step)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (b_in_mag == '0) ? ST_EMIT : ST_INT_DIV;
        end
      end
      ST_INT_DIV: begin
        if (cnt == STEP_CNT_WIDTH'(OPERAND_WIDTH - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = last_now ? ST_IDLE : ST_FRAC_LOAD;
        end
      end
      ST_FRAC_LOAD: begin
        state_next = ST_FRAC_DIV;
      end
      ST_FRAC_DIV: begin
        if (cnt == STEP_CNT_WIDTH'(DIGIT_WIDTH - 1)) begin
          state_next = ST_EMIT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EMIT: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          neg       <= dividend[OPERAND_WIDTH-1] ^ divisor[OPERAND_WIDTH-1];
          bmag      <= b_in_mag;
          dbz       <= (b_in_mag == '0);
          sh        <= a_in_mag;
          rem       <= '0;
          quo       <= '0;
          cnt       <= '0;
          cur_place <= '0;
          if (fraction_digits > DIGIT_WIDTH'(MAX_FRACTION_DIGITS)) begin
            digits <= DIGIT_WIDTH'(MAX_FRACTION_DIGITS);
          end else begin
            digits <= fraction_digits;
          end
        end
      end
      ST_INT_DIV, ST_FRAC_DIV: begin
        rem <= step.rem;
        quo <= {quo[OPERAND_WIDTH-2:0], step.qbit};
        sh  <= {sh[OPERAND_WIDTH-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      ST_FRAC_LOAD: begin
        cur_place <= cur_place + 1'b1;
        rem       <= {1'b0, ten_r[TEN_R_WIDTH-1:DIGIT_WIDTH]};
        sh        <= {ten_r[DIGIT_WIDTH-1:0], (OPERAND_WIDTH-DIGIT_WIDTH)'(0)};
        quo       <= '0;
        cnt       <= '0;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      digit_value    <= dbz ? '0 : quo;
      place          <= cur_place;
      negative       <= neg;
      divide_by_zero <= dbz;
      last           <= last_now;
    end
  end

`ifndef SYNTHESIS
  a_dbz_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> last && (digit_value == '0) && (place == '0))
    else $error("divide by zero result malformed");

  a_frac_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (place != '0) |-> digit_value < OPERAND_WIDTH'(RADIX))
    else $error("fraction digit out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");
`endif

endmodule
